FILE: src/bfh_pkg.sv
// ----------------------------------------------------------------------------
// bfh_pkg
// Shared types and constants for the back/forward page history block.
// ----------------------------------------------------------------------------
package bfh_pkg;

  localparam int DEPTH      = 128;
  localparam int PAGE_BITS  = 16;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int FIELD_BITS = 16;
  localparam int COUNT_BITS = 8;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  localparam logic [1:0] KIND_VISIT   = 2'd0;
  localparam logic [1:0] KIND_BACK    = 2'd1;
  localparam logic [1:0] KIND_FORWARD = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_BACK = 2'd1;
  localparam logic [1:0] ST_NO_FWD  = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FIELD_BITS-1:0] new_page;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] current_page;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] back_count;
    logic [COUNT_BITS-1:0] forward_count;
  } out_item_t;

endpackage

FILE: src/bfh_ram.sv
// ----------------------------------------------------------------------------
// bfh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/back_forward_history_stacks.sv
// ----------------------------------------------------------------------------
// back_forward_history_stacks
// Current page register with back and forward history stacks.
// ----------------------------------------------------------------------------
// The input channel carries one operation per transfer: visit a new page,
// go back or go forward. Every operation yields exactly one result transfer
// with the current page, a status code and both stack depths.
// A result appears in the output register in the cycle after its operation
// is accepted. Throughput is one operation per cycle while the output side
// keeps up. Each stack keeps its top entry in a register and its remaining
// entries in a RAM whose registered read port always prefetches the entry
// just below the top, so a pop never waits.
// When the receiver stalls with a result pending, the input is stalled as
// well and the held result does not change.
// Reset clears both depths, sets the current page to zero and empties the
// output register. The RAM contents are not cleared; only entries below the
// depth counts are ever used.
// ----------------------------------------------------------------------------
module back_forward_history_stacks
  import bfh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  page_t     page_r, page_nxt;
  cnt_t      bk_cnt_r, bk_cnt_nxt;
  cnt_t      fw_cnt_r, fw_cnt_nxt;
  page_t     bk_top_r, bk_top_nxt;
  page_t     fw_top_r, fw_top_nxt;
  page_t     bk_below;
  page_t     fw_below;
  logic      accept;
  logic      bk_push, bk_pop, fw_push, fw_pop;
  logic [1:0] status;
  cnt_t      bk_raddr_full, fw_raddr_full;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    bk_push  = 1'b0;
    bk_pop   = 1'b0;
    fw_push  = 1'b0;
    fw_pop   = 1'b0;
    status   = ST_OK;
    page_nxt = page_r;
    fw_cnt_nxt = fw_cnt_r;
    if (accept) begin
      unique case (in_data.kind)
        KIND_VISIT: begin
          if (bk_cnt_r == CNT_W'(DEPTH)) begin
            status = ST_DROPPED;
          end else begin
            bk_push = 1'b1;
          end
          page_nxt   = page_t'(in_data.new_page);
          fw_cnt_nxt = '0;
        end
        KIND_BACK: begin
          if (bk_cnt_r == '0) begin
            status = ST_NO_BACK;
          end else begin
            if (fw_cnt_r == CNT_W'(DEPTH)) begin
              status = ST_DROPPED;
            end else begin
              fw_push = 1'b1;
            end
            bk_pop   = 1'b1;
            page_nxt = bk_top_r;
          end
        end
        KIND_FORWARD: begin
          if (fw_cnt_r == '0) begin
            status = ST_NO_FWD;
          end else begin
            if (bk_cnt_r == CNT_W'(DEPTH)) begin
              status = ST_DROPPED;
            end else begin
              bk_push = 1'b1;
            end
            fw_pop   = 1'b1;
            page_nxt = fw_top_r;
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end

    bk_cnt_nxt = bk_cnt_r;
    bk_top_nxt = bk_top_r;
    if (bk_push) begin
      bk_cnt_nxt = bk_cnt_r + CNT_W'(1);
      bk_top_nxt = page_r;
    end else if (bk_pop) begin
      bk_cnt_nxt = bk_cnt_r - CNT_W'(1);
      bk_top_nxt = bk_below;
    end

    fw_top_nxt = fw_top_r;
    if (fw_push) begin
      fw_cnt_nxt = fw_cnt_r + CNT_W'(1);
      fw_top_nxt = page_r;
    end else if (fw_pop) begin
      fw_cnt_nxt = fw_cnt_r - CNT_W'(1);
      fw_top_nxt = fw_below;
    end

    bk_raddr_full = bk_cnt_nxt - CNT_W'(2);
    fw_raddr_full = fw_cnt_nxt - CNT_W'(2);

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.current_page  = FIELD_BITS'(page_nxt);
      out_data_nxt.status        = status;
      out_data_nxt.back_count    = COUNT_BITS'(bk_cnt_nxt);
      out_data_nxt.forward_count = COUNT_BITS'(fw_cnt_nxt);
    end
  end

  bfh_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (DEPTH)
  ) u_back_ram (
    .clk   (clk),
    .we    (bk_push),
    .waddr (bk_cnt_r[ADDR_W-1:0]),
    .wdata (page_r),
    .raddr (bk_raddr_full[ADDR_W-1:0]),
    .rdata (bk_below)
  );

  bfh_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (DEPTH)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (fw_push),
    .waddr (fw_cnt_r[ADDR_W-1:0]),
    .wdata (page_r),
    .raddr (fw_raddr_full[ADDR_W-1:0]),
    .rdata (fw_below)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      page_r      <= '0;
      bk_cnt_r    <= '0;
      fw_cnt_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      page_r      <= page_nxt;
      bk_cnt_r    <= bk_cnt_nxt;
      fw_cnt_r    <= fw_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    bk_top_r   <= bk_top_nxt;
    fw_top_r   <= fw_top_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_cnt_r <= CNT_W'(DEPTH)) && (fw_cnt_r <= CNT_W'(DEPTH)))
    else $error("history depth exceeds stack size");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted operation produced no result");

  a_visit_clears_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.kind == KIND_VISIT) |=> (out_data.forward_count == '0))
    else $error("visit left forward history behind");

  a_back_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.kind == KIND_BACK && bk_cnt_r == '0)
      |=> (out_data.status == ST_NO_BACK) && $stable(page_r))
    else $error("back on empty history changed state or status");
`endif

endmodule
